>>> src/matrix4_multiply_unit_defines.svh
// ----------------------------------------------------------------------------
// matrix4_multiply_unit_defines
// assertion macros used by the matrix multiply rtl
// ----------------------------------------------------------------------------
`ifndef MATRIX4_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX4_MULTIPLY_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MX4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MX4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mx4_pkg.sv
// ----------------------------------------------------------------------------
// mx4_pkg
// types and constants for the fixed-point matrix multiply unit
// ----------------------------------------------------------------------------
package mx4_pkg;

    localparam int DIM    = 4;
    localparam int CELLS  = DIM * DIM;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int FRAC_W = 16;
    localparam int DIX_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PROD_W = 2 * VAL_W;
    // exact sum of DIM full products plus a sign bit of headroom
    localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;

    typedef struct packed {
        logic signed [VAL_W-1:0] a_value;
        logic signed [VAL_W-1:0] b_value;
    } load_beat_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] c_value;
        logic [IDX_W-1:0]        c_index;
        logic                    last_result;
    } result_beat_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIX_W-1:0] row,
                                                    input logic [DIX_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(col);
    endfunction

endpackage

>>> src/matrix4_multiply_unit.sv
// per result: issue DIM products to the single shared mac, wait for its done, then
// emit the result and hold it while stalled; per run: 16 load beats, one pair a cycle
// compute throughput is bounded by the single shared mac
// the load channel stalls from the last load beat until the final result leaves
// reset clears the sequencer and load count; the stores hold no reset value
// ----------------------------------------------------------------------------
// matrix4_multiply_unit
// loads A and B pairwise in row-major order, then streams C = A * B in Q16.16
// ----------------------------------------------------------------------------
`include "matrix4_multiply_unit_defines.svh"

module matrix4_multiply_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_stall,
    input  mx4_pkg::load_beat_t   load_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mx4_pkg::result_beat_t result_data
);

    logic signed [mx4_pkg::VAL_W-1:0] left_mem  [mx4_pkg::CELLS];
    logic signed [mx4_pkg::VAL_W-1:0] right_mem [mx4_pkg::CELLS];

    mx4_pkg::state_t               state_reg;
    mx4_pkg::state_t               state_next;
    logic [mx4_pkg::ADDR_W-1:0]    load_count_reg;
    logic [mx4_pkg::ADDR_W-1:0]    load_count_next;
    logic [mx4_pkg::DIX_W-1:0]     row_reg;
    logic [mx4_pkg::DIX_W-1:0]     row_next;
    logic [mx4_pkg::DIX_W-1:0]     col_reg;
    logic [mx4_pkg::DIX_W-1:0]     col_next;
    logic [mx4_pkg::DIX_W-1:0]     k_reg;
    logic [mx4_pkg::DIX_W-1:0]     k_next;

    logic signed [mx4_pkg::VAL_W-1:0] left_rd_reg;
    logic signed [mx4_pkg::VAL_W-1:0] right_rd_reg;
    mx4_pkg::mac_ctl_t                rd_ctl_reg;
    mx4_pkg::mac_ctl_t                issue;

    logic signed [mx4_pkg::ACC_W-1:0] mac_sum;
    logic                             mac_done;
    logic signed [mx4_pkg::ACC_W-1:0] shifted;
    logic signed [mx4_pkg::VAL_W-1:0] sat_value;
    mx4_pkg::result_beat_t            out_reg;

    logic load_fire;
    logic result_fire;
    logic load_last;
    logic k_last;
    logic col_last;
    logic row_last;
    logic [mx4_pkg::ADDR_W-1:0] out_addr;

    assign load_fire   = load_valid & ~load_stall;
    assign result_fire = result_valid & ~result_stall;
    assign load_last   = (load_count_reg == mx4_pkg::ADDR_W'(mx4_pkg::CELLS - 1));
    assign k_last      = (k_reg == mx4_pkg::DIX_W'(mx4_pkg::DIM - 1));
    assign col_last    = (col_reg == mx4_pkg::DIX_W'(mx4_pkg::DIM - 1));
    assign row_last    = (row_reg == mx4_pkg::DIX_W'(mx4_pkg::DIM - 1));
    assign out_addr    = mx4_pkg::cell_addr(row_reg, col_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mx4_pkg::ST_LOAD:
            begin
                if (load_fire && load_last)
                    state_next = mx4_pkg::ST_ISSUE;
            end
            mx4_pkg::ST_ISSUE:
            begin
                if (k_last)
                    state_next = mx4_pkg::ST_WAIT;
            end
            mx4_pkg::ST_WAIT:
            begin
                if (mac_done)
                    state_next = mx4_pkg::ST_EMIT;
            end
            mx4_pkg::ST_EMIT:
            begin
                if (result_fire)
                    state_next = (row_last && col_last) ? mx4_pkg::ST_LOAD
                                                        : mx4_pkg::ST_ISSUE;
            end
            default:
                state_next = mx4_pkg::ST_LOAD;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        load_stall      = 1'b1;
        result_valid    = 1'b0;
        issue           = '0;
        load_count_next = load_count_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        k_next          = k_reg;
        case (state_reg)
            mx4_pkg::ST_LOAD:
            begin
                load_stall = 1'b0;
                if (load_fire)
                    load_count_next = load_last ? '0 : load_count_reg + 1'b1;
                row_next = '0;
                col_next = '0;
                k_next   = '0;
            end
            mx4_pkg::ST_ISSUE:
            begin
                issue.vld   = 1'b1;
                issue.first = (k_reg == '0);
                issue.last  = k_last;
                k_next      = k_last ? '0 : k_reg + 1'b1;
            end
            mx4_pkg::ST_WAIT:
            begin
                k_next = '0;
            end
            mx4_pkg::ST_EMIT:
            begin
                result_valid = 1'b1;
                if (result_fire)
                begin
                    col_next = col_last ? '0 : col_reg + 1'b1;
                    if (col_last)
                        row_next = row_last ? '0 : row_reg + 1'b1;
                end
            end
            default:
            begin
                load_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mx4_pkg::ST_LOAD;
            load_count_reg <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            k_reg          <= '0;
            rd_ctl_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            k_reg          <= k_next;
            rd_ctl_reg     <= issue;
        end
    end

    // operand stores, one write port and one registered read port each
    always_ff @(posedge clk)
    begin
        if (load_fire)
        begin
            left_mem[load_count_reg]  <= load_data.a_value;
            right_mem[load_count_reg] <= load_data.b_value;
        end
        if (issue.vld)
        begin
            left_rd_reg  <= left_mem[mx4_pkg::cell_addr(row_reg, k_reg)];
            right_rd_reg <= right_mem[mx4_pkg::cell_addr(k_reg, col_reg)];
        end
    end

    mx4_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (rd_ctl_reg),
        .a     (left_rd_reg),
        .b     (right_rd_reg),
        .sum   (mac_sum),
        .done  (mac_done)
    );

    // floor shift, then clamp to 32 bits
    assign shifted = mac_sum >>> mx4_pkg::FRAC_W;

    always_comb
    begin
        if ((&shifted[mx4_pkg::ACC_W-1:mx4_pkg::VAL_W-1]) ||
            (~|shifted[mx4_pkg::ACC_W-1:mx4_pkg::VAL_W-1]))
            sat_value = shifted[mx4_pkg::VAL_W-1:0];
        else if (shifted[mx4_pkg::ACC_W-1])
            sat_value = {1'b1, {(mx4_pkg::VAL_W-1){1'b0}}};
        else
            sat_value = {1'b0, {(mx4_pkg::VAL_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mx4_pkg::ST_WAIT && mac_done)
        begin
            out_reg.c_value     <= sat_value;
            out_reg.c_index     <= mx4_pkg::IDX_W'(out_addr);
            out_reg.last_result <= row_last & col_last;
        end
    end

    assign result_data = out_reg;

    `MX4_ASSERT_NOW(a_result_blocks_load, result_valid, load_stall,
                    "load accepted while a result beat is pending")
    `MX4_ASSERT_NOW(a_mac_done_in_wait, mac_done, state_reg == mx4_pkg::ST_WAIT,
                    "mac finished outside the wait state")
    `MX4_ASSERT_NEXT(a_run_end_reloads, result_fire && result_data.last_result,
                     state_reg == mx4_pkg::ST_LOAD && load_count_reg == '0,
                     "final result did not return to loading")
    `MX4_ASSERT_NOW(a_no_load_count_midrun, state_reg != mx4_pkg::ST_LOAD,
                    load_count_reg == '0,
                    "load count not cleared during compute")

endmodule

>>> src/mx4_mac.sv
// ----------------------------------------------------------------------------
// mx4_mac
// shared signed multiply-accumulate unit: registered product, exact sum
// ----------------------------------------------------------------------------
module mx4_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mx4_pkg::mac_ctl_t                 op,
    input  logic signed [mx4_pkg::VAL_W-1:0]  a,
    input  logic signed [mx4_pkg::VAL_W-1:0]  b,
    output logic signed [mx4_pkg::ACC_W-1:0]  sum,
    output logic                              done
);

    mx4_pkg::mac_ctl_t                   prod_ctl_reg;
    logic signed [mx4_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mx4_pkg::PROD_W-1:0]   prod_next;
    logic signed [mx4_pkg::ACC_W-1:0]    acc_reg;
    logic signed [mx4_pkg::ACC_W-1:0]    acc_next;
    logic                                done_reg;

    assign prod_next = a * b;

    always_comb
    begin
        if (prod_ctl_reg.first)
            acc_next = mx4_pkg::ACC_W'(prod_reg);
        else
            acc_next = acc_reg + mx4_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_ctl_reg <= op;
            done_reg     <= prod_ctl_reg.vld & prod_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.vld)
            prod_reg <= prod_next;
        if (prod_ctl_reg.vld)
            acc_reg <= acc_next;
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule

>>> tb/matrix4_multiply_unit_check.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_unit_check
// watches both channels, predicts C = A * B in Q16.16 and compares each result
// ----------------------------------------------------------------------------
module matrix4_multiply_unit_check (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    input  logic                  load_stall,
    input  mx4_pkg::load_beat_t   load_data,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  mx4_pkg::result_beat_t result_data,
    output int                    fail_count,
    output int                    pending
);

    import mx4_pkg::*;

    localparam int SUM_W = 68;
    localparam logic signed [SUM_W-1:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [SUM_W-1:0] SAT_LO = -68'sd2147483648;

    logic signed [VAL_W-1:0] left_cells  [CELLS];
    logic signed [VAL_W-1:0] right_cells [CELLS];
    int                      load_slot;
    int                      mismatches;
    result_beat_t            expected_products [$];
    result_beat_t            want;
    result_beat_t            predicted;

    // exact dot product, floor shift by the fraction width, then saturate
    function automatic logic signed [VAL_W-1:0] product_cell(input int row, input int col);
        logic signed [SUM_W-1:0]   acc;
        logic signed [PROD_W-1:0]  term;
        int                        k;
        acc = '0;
        for (k = 0; k < DIM; k++)
        begin
            term = left_cells[row * DIM + k] * right_cells[k * DIM + col];
            acc  = acc + term;
        end
        acc = acc >>> FRAC_W;
        if (acc > SAT_HI)
            acc = SAT_HI;
        else if (acc < SAT_LO)
            acc = SAT_LO;
        return acc[VAL_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            load_slot  = 0;
            mismatches = 0;
            expected_products.delete();
        end
        else
        begin
            if (load_valid && !load_stall)
            begin
                left_cells[load_slot]  = load_data.a_value;
                right_cells[load_slot] = load_data.b_value;
                if (load_slot == CELLS - 1)
                begin
                    load_slot = 0;
                    for (int idx = 0; idx < CELLS; idx++)
                    begin
                        predicted.c_value     = product_cell(idx / DIM, idx % DIM);
                        predicted.c_index     = IDX_W'(idx);
                        predicted.last_result = (idx == CELLS - 1);
                        expected_products.push_back(predicted);
                    end
                end
                else
                    load_slot++;
            end

            if (result_valid && !result_stall)
            begin
                if (expected_products.size() == 0)
                begin
                    $error("result beat with nothing expected: c_value %0d c_index %0d",
                           result_data.c_value, result_data.c_index);
                    mismatches++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (result_data.c_value !== want.c_value)
                    begin
                        $error("c_value: expected %0d, got %0d",
                               want.c_value, result_data.c_value);
                        mismatches++;
                    end
                    if (result_data.c_index !== want.c_index)
                    begin
                        $error("c_index: expected %0d, got %0d",
                               want.c_index, result_data.c_index);
                        mismatches++;
                    end
                    if (result_data.last_result !== want.last_result)
                    begin
                        $error("last_result: expected %0b, got %0b",
                               want.last_result, result_data.last_result);
                        mismatches++;
                    end
                end
            end
        end
        pending    <= expected_products.size();
        fail_count <= mismatches;
    end

endmodule

>>> tb/matrix4_multiply_unit_test.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_unit_test
// loads a directed matrix pair and many random ones under bursty load traffic
// and a shifting result stall pattern, then reports the checker's verdict
// ----------------------------------------------------------------------------
module matrix4_multiply_unit_test;

    import mx4_pkg::*;

    localparam int RANDOM_RUNS = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [VAL_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [VAL_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [VAL_W-1:0] Q_NEG1 = 32'hFFFF_0000;
    localparam logic [VAL_W-1:0] Q_LSB  = 32'h0000_0001;
    localparam logic [VAL_W-1:0] Q_ALL1 = 32'hFFFF_FFFF;

    typedef enum int {
        VAL_UNIT,
        VAL_FULL,
        VAL_EDGE,
        VAL_MIXED
    } value_style_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_RARE,
        STALL_HEAVY
    } stall_mode_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         load_valid;
    logic         load_stall;
    load_beat_t   load_data;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_beat_t result_data;

    int           fail_count;
    int           pending;
    int           cycle_count = 0;
    int           burst_left;
    int           stall_hold = 0;
    stall_mode_t  stall_mode = STALL_NONE;

    matrix4_multiply_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_stall   (load_stall),
        .load_data    (load_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    matrix4_multiply_unit_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (load_valid),
        .load_stall   (load_stall),
        .load_data    (load_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver switches to a random stall mode after each random hold
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_hold = $urandom_range(10, 60);
        end
        else
            stall_hold--;
        case (stall_mode)
            STALL_NONE:  result_stall <= 1'b0;
            STALL_HALF:  result_stall <= ($urandom_range(0, 1) == 1);
            STALL_RARE:  result_stall <= ($urandom_range(0, 7) == 0);
            default:     result_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic logic [VAL_W-1:0] draw_value(input value_style_t style);
        value_style_t pick;
        pick = style;
        if (pick == VAL_MIXED)
            pick = value_style_t'($urandom_range(0, 2));
        case (pick)
            VAL_UNIT:
                return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            VAL_EDGE:
                case ($urandom_range(0, 6))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return Q_ONE;
                    3:       return Q_NEG1;
                    4:       return Q_LSB;
                    5:       return Q_ALL1;
                    default: return '0;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    // one load beat; valid stays up inside a burst, drops for a random gap after
    task automatic push_pair(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        load_valid        <= 1'b1;
        load_data.a_value <= a;
        load_data.b_value <= b;
        @(posedge clk);
        while (load_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            load_valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48)
                                                     : $urandom_range(0, 10);
        end
        else
            burst_left--;
    endtask

    // rows and columns chosen so both saturation limits, the 2^64 sum of
    // min times min, floor rounding of negative products and identity all show up
    task automatic load_directed_pair();
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        int               row;
        int               col;
        for (int idx = 0; idx < CELLS; idx++)
        begin
            row = idx / DIM;
            col = idx % DIM;
            case (row)
                0:       a = Q_MAX;
                1:       a = Q_MIN;
                2:       a = (col == 0) ? Q_ONE : (col == 1) ? Q_ALL1 : (col == 2) ? '0 : Q_LSB;
                default: a = (col == 0) ? Q_NEG1 : (col == 1) ? 32'h0001_8000
                           : (col == 2) ? Q_MAX : Q_MIN;
            endcase
            case (col)
                0:       b = Q_MAX;
                1:       b = Q_MIN;
                2:       b = (row == 2) ? Q_ONE : '0;
                default: b = (row == 0) ? Q_ALL1 : (row == 1) ? Q_LSB : (row == 2) ? '0 : Q_NEG1;
            endcase
            push_pair(a, b);
        end
    endtask

    initial
    begin
        value_style_t style;
        rst_n      = 1'b0;
        load_valid = 1'b0;
        load_data  = '0;
        burst_left = $urandom_range(0, 10);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_directed_pair();

        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            style = value_style_t'($urandom_range(0, 3));
            for (int idx = 0; idx < CELLS; idx++)
                push_pair(draw_value(style), draw_value(style));
        end
        if (load_valid)
            load_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
